[src/bvg_pkg.sv]
// Package for the battery voltage gauge: widths, curve tables, register codes and shared types.
`timescale 1ns / 1ps
package bvg_pkg;

  localparam int FILTER_FRAC_BITS = 16;

  localparam int ADC_W      = 12;
  localparam int MV_W       = 15;
  localparam int RATIO_W    = 15;
  localparam int RATIO_FRAC = 12;
  localparam int ALPHA_W    = 16;
  localparam int ALPHA_FRAC = 16;
  localparam int PCT_W      = 7;
  localparam int PERCENT_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int FILT_W  = MV_W + FILTER_FRAC_BITS;
  localparam int SCALE_W = ADC_W + RATIO_W + 1;

  localparam int CURVE_POINTS = 12;
  localparam int SEG_W        = 4;
  localparam int CURVE_MV_W   = 13;
  localparam int DP_W         = 4;

  localparam logic [CURVE_MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    13'd4200, 13'd4100, 13'd4000, 13'd3930, 13'd3870, 13'd3820,
    13'd3790, 13'd3770, 13'd3740, 13'd3680, 13'd3550, 13'd3200
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0
  };

  // The widest segment spans 350 mV, and the rounded numerator stays below 3850 mV.
  localparam int OFF_W     = 9 + FILTER_FRAC_BITS;
  localparam int DIV_W     = 13 + FILTER_FRAC_BITS;
  localparam int DIV_STEPS = 4;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSE_PRESENT = 3'd0,
    REG_PIN_SCALE     = 3'd1,
    REG_SMOOTH_ALPHA  = 3'd2,
    REG_IMPLAUSIBLE   = 3'd3,
    REG_SENSOR_MAX    = 3'd4,
    REG_DEADBAND      = 3'd5,
    REG_LOW_PCT       = 3'd6,
    REG_CRITICAL_PCT  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic               sense_present;
    logic [RATIO_W-1:0] pin_scale;
    logic [ALPHA_W-1:0] smooth_alpha;
    logic [MV_W-1:0]    implausible_mv;
    logic [MV_W-1:0]    sensor_max_mv;
    logic [PCT_W-1:0]   deadband_pct;
    logic [PCT_W-1:0]   low_pct;
    logic [PCT_W-1:0]   critical_pct;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic diff;
    logic mul;
    logic upd;
    logic seg;
    logic num;
    logic div;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic sense_absent;
    logic fault;
  } sts_t;

  function automatic logic [FILT_W-1:0] curve_lo(input logic [SEG_W-1:0] idx);
    logic [FILT_W-1:0] mv;
    mv = FILT_W'(CURVE_MV[idx]);
    return mv << FILTER_FRAC_BITS;
  endfunction

endpackage

[src/battery_voltage_gauge.sv]
// Top level of the battery voltage gauge: configuration registers, controller and datapath.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   adc_millivolts
//   out      output     out_valid / out_stall battery_mv, percent, low_flag, critical_flag
//   cfg      input      cfg_wr_en             cfg_index, cfg_data
//
// A result reaches the output at the end of the sequence below; with sensing absent the word
// goes straight to completion, and on a fault it skips the division. The input stays stalled until the word completes.
// The sequence is set by the controller: scale, filter difference, filter multiply, update,
// segment search, numerator, four restoring division steps, then completion.
// A new word is accepted in the cycle after the previous result is written to the output register.
// A stalled output holds the controller in completion; the result register frees the input side.
// Synchronous reset clears the filter, marks the shown percentage as a fault, and loads
// the register defaults.
`timescale 1ns / 1ps
module battery_voltage_gauge
  import bvg_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ADC_W-1:0]            adc_millivolts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [MV_W-1:0]             battery_mv,
  output logic signed [PERCENT_W-1:0] percent,
  output logic                        low_flag,
  output logic                        critical_flag,
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sense_present  <= 1'b1;
      cfg.pin_scale      <= RATIO_W'(8192);
      cfg.smooth_alpha   <= ALPHA_W'(3277);
      cfg.implausible_mv <= MV_W'(3000);
      cfg.sensor_max_mv  <= MV_W'(4400);
      cfg.deadband_pct   <= PCT_W'(2);
      cfg.low_pct        <= PCT_W'(20);
      cfg.critical_pct   <= PCT_W'(5);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SENSE_PRESENT: cfg.sense_present  <= cfg_data[0];
        REG_PIN_SCALE:     cfg.pin_scale      <= cfg_data[RATIO_W-1:0];
        REG_SMOOTH_ALPHA:  cfg.smooth_alpha   <= cfg_data[ALPHA_W-1:0];
        REG_IMPLAUSIBLE:   cfg.implausible_mv <= cfg_data[MV_W-1:0];
        REG_SENSOR_MAX:    cfg.sensor_max_mv  <= cfg_data[MV_W-1:0];
        REG_DEADBAND:      cfg.deadband_pct   <= cfg_data[PCT_W-1:0];
        REG_LOW_PCT:       cfg.low_pct        <= cfg_data[PCT_W-1:0];
        REG_CRITICAL_PCT:  cfg.critical_pct   <= cfg_data[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bvg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bvg_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .adc_millivolts (adc_millivolts),
    .battery_mv     (battery_mv),
    .percent        (percent),
    .low_flag       (low_flag),
    .critical_flag  (critical_flag)
  );

endmodule

[src/bvg_ctrl.sv]
// Sequencing controller for the gauge: input and output handshakes and datapath commands.
`timescale 1ns / 1ps
module bvg_ctrl
  import bvg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCALE = 9'b000000010,
    S_DIFF  = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_UPD   = 9'b000010000,
    S_SEG   = 9'b000100000,
    S_NUM   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  state_t                state;
  state_t                state_next;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [DIV_CNT_W-1:0]  div_cnt_next;
  logic                  out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.sense_absent ? S_DONE : S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_SEG;
      end
      S_SEG: begin
        cmd.seg    = 1'b1;
        state_next = S_NUM;
      end
      S_NUM: begin
        cmd.num      = 1'b1;
        div_cnt_next = '0;
        state_next   = sts.fault ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.div      = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.finish | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_finish_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("A word was finished while the output slot was still occupied.");

  a_finish_shows_word: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("A finished word did not appear on the output.");

  a_absent_skips: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && sts.sense_absent) |=> (state == S_DONE))
    else $error("An input with sensing absent did not go straight to completion.");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == DIV_LAST) |=> (state == S_DONE))
    else $error("The division did not end after its last step.");
`endif

endmodule

[src/bvg_dp.sv]
// Datapath for the gauge: scaling, smoothing filter, curve lookup, division and deadband.
`timescale 1ns / 1ps
module bvg_dp
  import bvg_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  cfg_t                        cfg,
  input  cmd_t                        cmd,
  output sts_t                        sts,
  input  logic [ADC_W-1:0]            adc_millivolts,
  output logic [MV_W-1:0]             battery_mv,
  output logic signed [PERCENT_W-1:0] percent,
  output logic                        low_flag,
  output logic                        critical_flag
);

  localparam logic [SCALE_W-1:0] ROUND_HALF = SCALE_W'(1) << (RATIO_FRAC - 1);

  logic [ADC_W-1:0]            adc_q;
  logic [MV_W-1:0]             bat_q;
  logic                        up_q;
  logic [FILT_W-1:0]           d_q;
  logic [FILT_W-1:0]           s_q;
  logic [FILT_W-1:0]           filt;
  logic                        primed;
  logic signed [PERCENT_W-1:0] shown;
  logic                        fault_q;
  logic [SEG_W-1:0]            seg_q;
  logic                        top_q;
  logic                        bottom_q;
  logic [DIV_W-1:0]            rem_q;
  logic [DIV_W-1:0]            dsh_q;
  logic [DIV_STEPS-1:0]        quo_q;

  logic [SCALE_W-1:0]             scale_sum;
  logic [MV_W:0]                  bat_full;
  logic [FILT_W-1:0]              x_val;
  logic [FILT_W+ALPHA_W-1:0]      mul_full;
  logic [SEG_W-1:0]               seg_c;
  logic                           found_c;
  logic                           fault_c;
  logic [FILT_W-1:0]              lo_val;
  logic [FILT_W-1:0]              hi_val;
  logic [OFF_W-1:0]               off_val;
  logic [DIV_W-1:0]               span_val;
  logic [DP_W-1:0]                dp_val;
  logic [DIV_W-1:0]               num_val;
  logic [PCT_W-1:0]               raw;
  logic signed [PERCENT_W:0]      drift_s;
  logic [PERCENT_W:0]             drift;
  logic signed [PERCENT_W-1:0]    shown_next;

  assign sts.sense_absent = ~cfg.sense_present;
  assign sts.fault        = fault_q;

  assign scale_sum = SCALE_W'(adc_q) * SCALE_W'(cfg.pin_scale) + ROUND_HALF;
  assign bat_full  = scale_sum[SCALE_W-1:RATIO_FRAC];
  assign x_val     = {bat_q, {FILTER_FRAC_BITS{1'b0}}};
  assign mul_full  = {{ALPHA_W{1'b0}}, d_q} * {{FILT_W{1'b0}}, cfg.smooth_alpha};

  always_comb begin
    seg_c   = SEG_W'(1);
    found_c = 1'b0;
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (filt >= curve_lo(SEG_W'(i))) begin
        seg_c   = SEG_W'(i);
        found_c = 1'b1;
      end
    end
  end

  assign fault_c = (filt < {cfg.implausible_mv, {FILTER_FRAC_BITS{1'b0}}}) ||
                   (filt > {cfg.sensor_max_mv, {FILTER_FRAC_BITS{1'b0}}});

  assign lo_val   = curve_lo(seg_q);
  assign hi_val   = curve_lo(seg_q - 1'b1);
  assign off_val  = OFF_W'(filt - lo_val);
  assign span_val = DIV_W'(hi_val - lo_val);
  assign dp_val   = DP_W'(CURVE_PCT[seg_q - 1'b1] - CURVE_PCT[seg_q]);
  assign num_val  = ((DIV_W'(off_val) * DIV_W'(dp_val)) << 1) + span_val;

  always_comb begin
    if (top_q) begin
      raw = PCT_FULL;
    end else if (bottom_q) begin
      raw = '0;
    end else begin
      raw = CURVE_PCT[seg_q] + PCT_W'(quo_q);
    end
  end

  assign drift_s = $signed({2'b00, raw}) - $signed({shown[PERCENT_W-1], shown});
  assign drift   = drift_s[PERCENT_W] ? (PERCENT_W+1)'(0) - drift_s : drift_s;

  always_comb begin
    shown_next = shown;
    if (fault_q) begin
      shown_next = -PERCENT_W'(1);
    end else if (shown[PERCENT_W-1] || (raw >= PCT_FULL) || (raw == '0) ||
                 (drift >= {2'b00, cfg.deadband_pct})) begin
      shown_next = $signed({1'b0, raw});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      adc_q <= adc_millivolts;
    end
    if (cmd.scale) begin
      bat_q <= bat_full[MV_W] ? {MV_W{1'b1}} : bat_full[MV_W-1:0];
    end
    if (cmd.diff) begin
      up_q <= (x_val >= filt);
      d_q  <= (x_val >= filt) ? x_val - filt : filt - x_val;
    end
    if (cmd.mul) begin
      s_q <= mul_full[FILT_W+ALPHA_FRAC-1:ALPHA_FRAC];
    end
    if (cmd.seg) begin
      fault_q  <= fault_c;
      seg_q    <= seg_c;
      top_q    <= (filt >= curve_lo('0));
      bottom_q <= ~found_c;
    end
    if (cmd.num) begin
      rem_q <= num_val;
      dsh_q <= span_val << DIV_STEPS;
      quo_q <= '0;
    end
    if (cmd.div) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[DIV_STEPS-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[DIV_STEPS-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
    if (cmd.finish) begin
      if (!cfg.sense_present) begin
        battery_mv    <= '0;
        percent       <= '0;
        low_flag      <= 1'b0;
        critical_flag <= 1'b0;
      end else begin
        battery_mv    <= bat_q;
        percent       <= shown_next;
        low_flag      <= !shown_next[PERCENT_W-1] &&
                         (shown_next[PCT_W-1:0] <= cfg.low_pct);
        critical_flag <= !shown_next[PERCENT_W-1] &&
                         (shown_next[PCT_W-1:0] <= cfg.critical_pct);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt   <= '0;
      primed <= 1'b0;
      shown  <= -PERCENT_W'(1);
    end else begin
      if (cmd.upd) begin
        primed <= 1'b1;
        if (!primed) begin
          filt <= x_val;
        end else if (up_q) begin
          filt <= filt + s_q;
        end else begin
          filt <= filt - s_q;
        end
      end
      if (cmd.finish && cfg.sense_present) begin
        shown <= shown_next;
      end
    end
  end

endmodule
